// ----- rtl/mrm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, codes and the CRC-16/MODBUS byte step for the Modbus RTU
// master transaction block.
// ----------------------------------------------------------------------------
package mrm_pkg;

   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_RXBYTE  = 2'd2,
      OP_TIMEOUT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_REQ    = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_UNIT  = 4'd1,
      PH_FUNC  = 4'd2,
      PH_EXC   = 4'd3,
      PH_COUNT = 4'd4,
      PH_DATA  = 4'd5,
      PH_ECHO  = 4'd6,
      PH_CRCLO = 4'd7,
      PH_CRCHI = 4'd8
   } phase_type;

   typedef enum logic {
      MODE_IDLE = 1'b0,
      MODE_SEND = 1'b1
   } mode_type;

   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_BAD_UNIT    = 4'd1;
   localparam logic [3:0] ST_BAD_FUNC    = 4'd2;
   localparam logic [3:0] ST_EXC_BASE    = 4'd2;
   localparam logic [3:0] ST_EXC_UNKNOWN = 4'd7;
   localparam logic [3:0] ST_ECHO_ADDR   = 4'd8;
   localparam logic [3:0] ST_ECHO_VALUE  = 4'd9;
   localparam logic [3:0] ST_CRC         = 4'd10;
   localparam logic [3:0] ST_TIMEOUT     = 4'd11;

   localparam logic [7:0] FUNC_READ  = 8'h03;
   localparam logic [7:0] FUNC_WRITE = 8'h06;
   localparam logic [7:0] EXC_READ   = 8'h83;
   localparam logic [7:0] EXC_WRITE  = 8'h86;
   localparam logic [7:0] EXC_MIN    = 8'h01;
   localparam logic [7:0] EXC_MAX    = 8'h04;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [2:0] TX_LAST = 3'd7;
   localparam logic [2:0] TX_CRC_LO = 3'd6;

   typedef struct packed {
      op_type      op;
      logic [7:0]  unit;
      logic [15:0] reg_addr;
      logic [15:0] value;
      logic [7:0]  rx;
   } cmd_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_value;
      logic       last;
      logic [3:0] status;
      logic [7:0] exc;
   } rsp_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mrm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrm_front
// Accepts request beats, classifies the action and holds them in a
// two-entry queue for the transaction engine.
// ----------------------------------------------------------------------------
module mrm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_action,
   input  wire logic [7:0]       req_target_unit,
   input  wire logic [15:0]      req_start_register,
   input  wire logic [15:0]      req_count_or_value,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  cmd_valid,
   output mrm_pkg::cmd_type      cmd,
   input  wire logic             cmd_pop
);

   mrm_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   logic             pop;
   mrm_pkg::cmd_type new_cmd;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op       = mrm_pkg::op_type'(req_action);
      new_cmd.unit     = req_target_unit;
      new_cmd.reg_addr = req_start_register;
      new_cmd.value    = req_count_or_value;
      new_cmd.rx       = req_rx_byte;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/mrm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrm_back
// Transaction engine: sends the request frame byte by byte with its CRC,
// then checks the reply one byte per command and drives the result register.
// ----------------------------------------------------------------------------
module mrm_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire mrm_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   output mrm_pkg::rsp_type      rsp,
   input  wire logic             rsp_stall
);

   mrm_pkg::mode_type  mode_ff, mode_in;
   mrm_pkg::phase_type phase_ff, phase_in;
   logic               is_write_ff, is_write_in;
   logic [7:0]         unit_ff, unit_in;
   logic [15:0]        reg_ff, reg_in;
   logic [15:0]        val_ff, val_in;
   logic [7:0]         byte_count_ff, byte_count_in;
   logic [7:0]         bytes_seen_ff, bytes_seen_in;
   logic [15:0]        crc_ff, crc_in;
   logic [15:0]        echo_ff, echo_in;
   logic [7:0]         crc_lo_ff, crc_lo_in;
   logic [2:0]         tx_idx_ff, tx_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mrm_pkg::rsp_type   rsp_ff, rsp_in;

   logic               out_ready;
   logic               rsp_load;
   logic [7:0]         tx_byte;
   logic [7:0]         b;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign b         = cmd.rx;

   always_comb begin
      unique case (tx_idx_ff)
         3'd0: tx_byte = unit_ff;
         3'd1: tx_byte = is_write_ff ? mrm_pkg::FUNC_WRITE : mrm_pkg::FUNC_READ;
         3'd2: tx_byte = reg_ff[15:8];
         3'd3: tx_byte = reg_ff[7:0];
         3'd4: tx_byte = val_ff[15:8];
         3'd5: tx_byte = val_ff[7:0];
         3'd6: tx_byte = crc_ff[7:0];
         default: tx_byte = crc_ff[15:8];
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      phase_in      = phase_ff;
      is_write_in   = is_write_ff;
      unit_in       = unit_ff;
      reg_in        = reg_ff;
      val_in        = val_ff;
      byte_count_in = byte_count_ff;
      bytes_seen_in = bytes_seen_ff;
      crc_in        = crc_ff;
      echo_in       = echo_ff;
      crc_lo_in     = crc_lo_ff;
      tx_idx_in     = tx_idx_ff;
      cmd_pop       = 1'b0;
      rsp_load      = 1'b0;
      rsp_in        = '0;

      unique case (mode_ff)
         mrm_pkg::MODE_SEND: begin
            if (out_ready) begin
               rsp_load          = 1'b1;
               rsp_in.kind       = mrm_pkg::KIND_REQ;
               rsp_in.byte_value = tx_byte;
               rsp_in.last       = (tx_idx_ff == mrm_pkg::TX_LAST);
               tx_idx_in         = tx_idx_ff + 3'd1;
               if (tx_idx_ff < mrm_pkg::TX_CRC_LO) begin
                  crc_in = mrm_pkg::crc_feed(crc_ff, tx_byte);
               end
               if (tx_idx_ff == mrm_pkg::TX_LAST) begin
                  crc_in  = mrm_pkg::CRC_INIT;
                  mode_in = mrm_pkg::MODE_IDLE;
               end
            end
         end
         mrm_pkg::MODE_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == mrm_pkg::OP_READ || cmd.op == mrm_pkg::OP_WRITE) begin
                  cmd_pop       = 1'b1;
                  is_write_in   = (cmd.op == mrm_pkg::OP_WRITE);
                  unit_in       = cmd.unit;
                  reg_in        = cmd.reg_addr;
                  val_in        = cmd.value;
                  byte_count_in = 8'd0;
                  bytes_seen_in = 8'd0;
                  echo_in       = 16'd0;
                  crc_lo_in     = 8'd0;
                  crc_in        = mrm_pkg::CRC_INIT;
                  phase_in      = mrm_pkg::PH_UNIT;
                  tx_idx_in     = 3'd0;
                  mode_in       = mrm_pkg::MODE_SEND;
               end else if (phase_ff == mrm_pkg::PH_IDLE) begin
                  cmd_pop = 1'b1;
               end else if (out_ready) begin
                  cmd_pop = 1'b1;
                  if (cmd.op == mrm_pkg::OP_TIMEOUT) begin
                     rsp_load      = 1'b1;
                     rsp_in.kind   = mrm_pkg::KIND_STATUS;
                     rsp_in.status = mrm_pkg::ST_TIMEOUT;
                     phase_in      = mrm_pkg::PH_IDLE;
                  end else begin
                     unique case (phase_ff)
                        mrm_pkg::PH_UNIT: begin
                           if (b != unit_ff) begin
                              rsp_load      = 1'b1;
                              rsp_in.kind   = mrm_pkg::KIND_STATUS;
                              rsp_in.status = mrm_pkg::ST_BAD_UNIT;
                              phase_in      = mrm_pkg::PH_IDLE;
                           end else begin
                              crc_in   = mrm_pkg::crc_feed(crc_ff, b);
                              phase_in = mrm_pkg::PH_FUNC;
                           end
                        end
                        mrm_pkg::PH_FUNC: begin
                           priority if (b == (is_write_ff ? mrm_pkg::EXC_WRITE
                                                          : mrm_pkg::EXC_READ)) begin
                              phase_in = mrm_pkg::PH_EXC;
                           end else if (b == (is_write_ff ? mrm_pkg::FUNC_WRITE
                                                          : mrm_pkg::FUNC_READ)) begin
                              crc_in        = mrm_pkg::crc_feed(crc_ff, b);
                              phase_in      = is_write_ff ? mrm_pkg::PH_ECHO
                                                          : mrm_pkg::PH_COUNT;
                              bytes_seen_in = 8'd0;
                           end else begin
                              rsp_load      = 1'b1;
                              rsp_in.kind   = mrm_pkg::KIND_STATUS;
                              rsp_in.status = mrm_pkg::ST_BAD_FUNC;
                              phase_in      = mrm_pkg::PH_IDLE;
                           end
                        end
                        mrm_pkg::PH_EXC: begin
                           rsp_load    = 1'b1;
                           rsp_in.kind = mrm_pkg::KIND_STATUS;
                           rsp_in.exc  = b;
                           if (b >= mrm_pkg::EXC_MIN && b <= mrm_pkg::EXC_MAX) begin
                              rsp_in.status = b[3:0] + mrm_pkg::ST_EXC_BASE;
                           end else begin
                              rsp_in.status = mrm_pkg::ST_EXC_UNKNOWN;
                           end
                           phase_in = mrm_pkg::PH_IDLE;
                        end
                        mrm_pkg::PH_COUNT: begin
                           crc_in        = mrm_pkg::crc_feed(crc_ff, b);
                           byte_count_in = b;
                           bytes_seen_in = 8'd0;
                           phase_in      = (b == 8'd0) ? mrm_pkg::PH_CRCLO
                                                       : mrm_pkg::PH_DATA;
                        end
                        mrm_pkg::PH_DATA: begin
                           crc_in        = mrm_pkg::crc_feed(crc_ff, b);
                           bytes_seen_in = bytes_seen_ff + 8'd1;
                           if (bytes_seen_in == byte_count_ff) begin
                              phase_in = mrm_pkg::PH_CRCLO;
                           end
                           rsp_load          = 1'b1;
                           rsp_in.kind       = mrm_pkg::KIND_DATA;
                           rsp_in.byte_value = b;
                        end
                        mrm_pkg::PH_ECHO: begin
                           crc_in        = mrm_pkg::crc_feed(crc_ff, b);
                           echo_in       = {echo_ff[7:0], b};
                           bytes_seen_in = bytes_seen_ff + 8'd1;
                           priority if (bytes_seen_in == 8'd2 && echo_in != reg_ff) begin
                              rsp_load      = 1'b1;
                              rsp_in.kind   = mrm_pkg::KIND_STATUS;
                              rsp_in.status = mrm_pkg::ST_ECHO_ADDR;
                              phase_in      = mrm_pkg::PH_IDLE;
                           end else if (bytes_seen_in >= 8'd4) begin
                              if (echo_in != val_ff) begin
                                 rsp_load      = 1'b1;
                                 rsp_in.kind   = mrm_pkg::KIND_STATUS;
                                 rsp_in.status = mrm_pkg::ST_ECHO_VALUE;
                                 phase_in      = mrm_pkg::PH_IDLE;
                              end else begin
                                 phase_in = mrm_pkg::PH_CRCLO;
                              end
                           end else begin
                              phase_in = phase_ff;
                           end
                        end
                        mrm_pkg::PH_CRCLO: begin
                           crc_lo_in = b;
                           phase_in  = mrm_pkg::PH_CRCHI;
                        end
                        mrm_pkg::PH_CRCHI: begin
                           rsp_load    = 1'b1;
                           rsp_in.kind = mrm_pkg::KIND_STATUS;
                           if (crc_lo_ff == crc_ff[7:0] && b == crc_ff[15:8]) begin
                              rsp_in.status = mrm_pkg::ST_OK;
                           end else begin
                              rsp_in.status = mrm_pkg::ST_CRC;
                           end
                           phase_in = mrm_pkg::PH_IDLE;
                        end
                        default: begin
                           phase_in = mrm_pkg::PH_IDLE;
                        end
                     endcase
                  end
               end
            end
         end
         default: begin
            mode_in = mrm_pkg::MODE_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= mrm_pkg::MODE_IDLE;
         phase_ff      <= mrm_pkg::PH_IDLE;
         is_write_ff   <= 1'b0;
         unit_ff       <= 8'd0;
         reg_ff        <= 16'd0;
         val_ff        <= 16'd0;
         byte_count_ff <= 8'd0;
         bytes_seen_ff <= 8'd0;
         crc_ff        <= mrm_pkg::CRC_INIT;
         echo_ff       <= 16'd0;
         crc_lo_ff     <= 8'd0;
         tx_idx_ff     <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         is_write_ff   <= is_write_in;
         unit_ff       <= unit_in;
         reg_ff        <= reg_in;
         val_ff        <= val_in;
         byte_count_ff <= byte_count_in;
         bytes_seen_ff <= bytes_seen_in;
         crc_ff        <= crc_in;
         echo_ff       <= echo_in;
         crc_lo_ff     <= crc_lo_in;
         tx_idx_ff     <= tx_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/modbus_rtu_master_transaction_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction_top
// Modbus RTU master for one read-holding or write-single transaction at a
// time: builds the request frame and checks the reply byte by byte.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue at up to one per cycle while req_stall is
// low. The engine loads a start item, then sends the eight request beats,
// one per cycle while rsp_stall is low, with the CRC advanced a byte per
// cycle over the first six bytes. A new start drops any transaction in
// progress without a status beat; bytes and timeouts that arrive while no
// transaction is open are dropped silently.
module modbus_rtu_master_transaction_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_target_unit,
   input  wire logic [15:0] req_start_register,
   input  wire logic [15:0] req_count_or_value,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_byte_value,
   output logic             rsp_last,
   output logic [3:0]       rsp_status,
   output logic [7:0]       rsp_exception_code
);

   logic             cmd_valid;
   logic             cmd_pop;
   mrm_pkg::cmd_type cmd;
   mrm_pkg::rsp_type rsp;

   mrm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_target_unit    (req_target_unit),
      .req_start_register (req_start_register),
      .req_count_or_value (req_count_or_value),
      .req_rx_byte        (req_rx_byte),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop)
   );

   mrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   assign rsp_kind           = rsp.kind;
   assign rsp_byte_value     = rsp.byte_value;
   assign rsp_last           = rsp.last;
   assign rsp_status         = rsp.status;
   assign rsp_exception_code = rsp.exc;

   a_last_is_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == mrm_pkg::KIND_REQ)
      else $error("last flag on a non-request beat");

   a_status_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mrm_pkg::KIND_STATUS |-> rsp_byte_value == 8'd0)
      else $error("status beat carries a byte value");

   a_exc_only_in_exception: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exception_code != 8'd0 |->
         rsp_kind == mrm_pkg::KIND_STATUS && rsp_status >= 4'd3 && rsp_status <= 4'd7)
      else $error("exception code outside an exception status");

endmodule
`default_nettype wire
